/* rtl/pcv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcv_pkg;

   localparam int unsigned MaxNameBytesDefault = 255;
   localparam int unsigned BasePrefixDepth     = 5;
   // Base length saturates here, meaning "longer than the prefix".
   localparam logic [2:0]  BaseLenSaturated    = 3'd6;

   localparam logic [7:0] CharSpace     = 8'h20;
   localparam logic [7:0] CharDel       = 8'h7F;
   localparam logic [7:0] CharDot       = 8'h2E;
   localparam logic [7:0] CharQuote     = 8'h22;
   localparam logic [7:0] CharStar      = 8'h2A;
   localparam logic [7:0] CharSlash     = 8'h2F;
   localparam logic [7:0] CharColon     = 8'h3A;
   localparam logic [7:0] CharLess      = 8'h3C;
   localparam logic [7:0] CharGreater   = 8'h3E;
   localparam logic [7:0] CharQuestion  = 8'h3F;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharPipe      = 8'h7C;
   localparam logic [7:0] CharDigit1    = 8'h31;
   localparam logic [7:0] CharDigit9    = 8'h39;

   localparam logic [7:0] LeadTwoLow    = 8'hC2;
   localparam logic [7:0] LeadTwoHigh   = 8'hDF;
   localparam logic [7:0] LeadThreeLow  = 8'hE0;
   localparam logic [7:0] LeadThreeHigh = 8'hEF;
   localparam logic [7:0] LeadSurrogate = 8'hED;
   localparam logic [7:0] LeadFourLow   = 8'hF0;
   localparam logic [7:0] LeadFourHigh  = 8'hF4;
   localparam logic [7:0] SuperOne      = 8'hB9;
   localparam logic [7:0] SuperTwo      = 8'hB2;
   localparam logic [7:0] SuperThree    = 8'hB3;

   typedef enum logic [2:0] {
      CONT_NORMAL  = 3'd0,   // 80-BF
      CONT_FROM_A0 = 3'd1,   // A0-BF
      CONT_TO_9F   = 3'd2,   // 80-9F
      CONT_FROM_90 = 3'd3,   // 90-BF
      CONT_TO_8F   = 3'd4    // 80-8F
   } cont_class_type;

   typedef logic [7:0] prefix_type [BasePrefixDepth];

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      fold_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic cont_ok(input logic [7:0] b, input cont_class_type cls);
      case (cls)
         CONT_FROM_A0: cont_ok = (b >= 8'hA0 && b <= 8'hBF);
         CONT_TO_9F:   cont_ok = (b >= 8'h80 && b <= 8'h9F);
         CONT_FROM_90: cont_ok = (b >= 8'h90 && b <= 8'hBF);
         CONT_TO_8F:   cont_ok = (b >= 8'h80 && b <= 8'h8F);
         default:      cont_ok = (b >= 8'h80 && b <= 8'hBF);
      endcase
   endfunction

   function automatic logic forbidden_ascii(input logic [7:0] b);
      forbidden_ascii = (b < CharSpace) || (b == CharDel) ||
                        (b == CharLess) || (b == CharGreater) || (b == CharColon) ||
                        (b == CharQuote) || (b == CharSlash) || (b == CharBackslash) ||
                        (b == CharPipe) || (b == CharQuestion) || (b == CharStar);
   endfunction

   function automatic logic base_is(input prefix_type p, input logic [23:0] w);
      base_is = (fold_lower(p[0]) == w[23:16]) && (fold_lower(p[1]) == w[15:8]) &&
                (fold_lower(p[2]) == w[7:0]);
   endfunction

   function automatic logic base_reserved(input prefix_type p, input logic [2:0] len);
      logic comlpt;
      comlpt = base_is(p, "com") || base_is(p, "lpt");
      case (len)
         3'd3: base_reserved = base_is(p, "con") || base_is(p, "prn") ||
                               base_is(p, "aux") || base_is(p, "nul");
         3'd4: base_reserved = comlpt && p[3] >= CharDigit1 && p[3] <= CharDigit9;
         3'd5: base_reserved = comlpt && p[3] == LeadTwoLow &&
                               (p[4] == SuperOne || p[4] == SuperTwo || p[4] == SuperThree);
         default: base_reserved = 1'b0;
      endcase
   endfunction

endpackage

`default_nettype wire

/* rtl/path_component_validator_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   data_byte, last_byte, empty_name
// rsp_      out        rsp_valid/rsp_stall   name_valid
//
// One request is taken per cycle while req_stall is low; each byte updates the decoder state in the cycle it
// is accepted, through a single level of logic into the state registers.
// The answer for an ending request sits in the response register in the cycle after it is accepted.
// Requests are stalled only while a response is held and the receiver stalls it.
// Reset is synchronous and clears the decoder state (not the base prefix bytes) and the response valid flag.
module path_component_validator_top
   import pcv_pkg::*;
#(
   parameter int unsigned MAX_NAME_BYTES = MaxNameBytesDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_empty_name,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_name_valid
);

   localparam int unsigned CountWidth = $clog2(MAX_NAME_BYTES + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_NAME_BYTES);

   logic [CountWidth-1:0] byte_count_ff, byte_count_in;
   logic [1:0]            cont_left_ff, cont_left_in;
   cont_class_type        cont_class_ff, cont_class_in;
   logic                  error_ff, error_in;
   prefix_type            prefix_ff, prefix_in;
   logic [2:0]            base_len_ff, base_len_in;
   logic                  dot_seen_ff, dot_seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_name_valid_ff, rsp_name_valid_in;

   logic req_accept;
   logic ends_name;
   logic verdict;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign ends_name  = req_last_byte || req_empty_name;

   always_comb begin
      byte_count_in = byte_count_ff;
      cont_left_in  = cont_left_ff;
      cont_class_in = cont_class_ff;
      error_in      = error_ff;
      prefix_in     = prefix_ff;
      base_len_in   = base_len_ff;
      dot_seen_in   = dot_seen_ff;
      verdict       = 1'b0;

      if (byte_count_ff >= CountMax) begin
         error_in = 1'b1;
      end else begin
         byte_count_in = byte_count_ff + CountWidth'(1);
      end

      if (cont_left_ff != 2'd0) begin
         if (cont_ok(req_data_byte, cont_class_ff)) begin
            cont_left_in = cont_left_ff - 2'd1;
         end else begin
            error_in     = 1'b1;
            cont_left_in = 2'd0;
         end
         cont_class_in = CONT_NORMAL;
      end else if (req_data_byte <= CharDel) begin
         if (forbidden_ascii(req_data_byte)) begin
            error_in = 1'b1;
         end
      end else if (req_data_byte >= LeadTwoLow && req_data_byte <= LeadTwoHigh) begin
         cont_left_in  = 2'd1;
         cont_class_in = CONT_NORMAL;
      end else if (req_data_byte >= LeadThreeLow && req_data_byte <= LeadThreeHigh) begin
         cont_left_in  = 2'd2;
         cont_class_in = (req_data_byte == LeadThreeLow)  ? CONT_FROM_A0 :
                         (req_data_byte == LeadSurrogate) ? CONT_TO_9F : CONT_NORMAL;
      end else if (req_data_byte >= LeadFourLow && req_data_byte <= LeadFourHigh) begin
         cont_left_in  = 2'd3;
         cont_class_in = (req_data_byte == LeadFourLow)  ? CONT_FROM_90 :
                         (req_data_byte == LeadFourHigh) ? CONT_TO_8F : CONT_NORMAL;
      end else begin
         error_in = 1'b1;
      end

      if (!dot_seen_ff) begin
         if (req_data_byte == CharDot) begin
            dot_seen_in = 1'b1;
         end else begin
            for (int i = 0; i < BasePrefixDepth; i++) begin
               if (base_len_ff == 3'(i)) begin
                  prefix_in[i] = req_data_byte;
               end
            end
            if (base_len_ff < BaseLenSaturated) begin
               base_len_in = base_len_ff + 3'd1;
            end
         end
      end

      verdict = !error_in && (cont_left_in == 2'd0) && (req_data_byte != CharDot) &&
                (req_data_byte != CharSpace) && !base_reserved(prefix_in, base_len_in);

      // The name ends here: the state goes back to its reset values.
      if (ends_name) begin
         byte_count_in = '0;
         cont_left_in  = 2'd0;
         cont_class_in = CONT_NORMAL;
         error_in      = 1'b0;
         base_len_in   = 3'd0;
         dot_seen_in   = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_name_valid_in = rsp_name_valid_ff;
      if (req_accept && ends_name) begin
         rsp_valid_in      = 1'b1;
         rsp_name_valid_in = !req_empty_name && verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         cont_left_ff  <= 2'd0;
         cont_class_ff <= CONT_NORMAL;
         error_ff      <= 1'b0;
         base_len_ff   <= 3'd0;
         dot_seen_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            byte_count_ff <= byte_count_in;
            cont_left_ff  <= cont_left_in;
            cont_class_ff <= cont_class_in;
            error_ff      <= error_in;
            base_len_ff   <= base_len_in;
            dot_seen_ff   <= dot_seen_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         prefix_ff <= prefix_in;
      end
      rsp_name_valid_ff <= rsp_name_valid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_name_valid = rsp_name_valid_ff;

   assert property (@(posedge clock) disable iff (reset) byte_count_ff <= CountMax)
      else $error("byte counter passed the name limit");

   assert property (@(posedge clock) disable iff (reset)
      (cont_class_ff != CONT_NORMAL) |-> (cont_left_ff >= 2'd2))
      else $error("restricted continuation range without a pending multi-byte lead");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_last_byte || req_empty_name)) |=>
         (byte_count_ff == '0 && cont_left_ff == 2'd0 && !error_ff && !dot_seen_ff &&
          base_len_ff == 3'd0))
      else $error("decoder state not cleared after the end of a name");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_empty_name) |=> (rsp_valid_ff && !rsp_name_valid_ff))
      else $error("empty name not answered as invalid");

   assert property (@(posedge clock) disable iff (reset) base_len_ff <= BaseLenSaturated)
      else $error("base length passed its saturation value");

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import pcv_pkg::*;

   localparam int unsigned TotalItems    = 1500;
   localparam int unsigned IdlePercent   = 28;
   localparam int unsigned HoldOffCycles = 200;
   localparam int unsigned QuietLimit    = 3000;
   localparam int unsigned DrainCycles   = 10;
   localparam int          NoWant        = -1;
   localparam int          RowCount      = 24;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       req_empty_name;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_name_valid;

   path_component_validator_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .req_empty_name (req_empty_name),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_name_valid (rsp_name_valid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shared between the request driver, the response side and the checker.
   bit   verdicts_due [$];
   int   items_sent;
   int   mismatch_count;
   int   names_checked;
   int   names_accepted;
   int   quiet_cycles;
   bit   idle_enabled = 1'b1;
   bit   hold_request = 1'b0;
   bit   expected_verdict;

   function automatic void queue_verdict(input bit v);
      verdicts_due.insert(verdicts_due.size(), v);
   endfunction

   // Predictor state for the component currently being received.
   logic [8:0]     name_count;
   logic [1:0]     name_cont_left;
   cont_class_type name_cont_class;
   bit             name_bad;
   logic [7:0]     name_base [BasePrefixDepth];
   logic [2:0]     name_base_len;
   bit             name_dot_seen;

   function automatic void clear_name_state();
      name_count      = '0;
      name_cont_left  = '0;
      name_cont_class = CONT_NORMAL;
      name_bad        = 1'b0;
      foreach (name_base[i]) name_base[i] = '0;
      name_base_len   = '0;
      name_dot_seen   = 1'b0;
   endfunction

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
   endfunction

   function automatic bit base_is_device();
      logic [23:0] stem;
      bit          com_or_lpt;
      stem = {lower_ascii(name_base[0]), lower_ascii(name_base[1]), lower_ascii(name_base[2])};
      com_or_lpt = (stem == "com") || (stem == "lpt");
      case (name_base_len)
         3'd3: return stem inside {"con", "prn", "aux", "nul"};
         3'd4: return com_or_lpt && (name_base[3] inside {[CharDigit1:CharDigit9]});
         3'd5: return com_or_lpt && name_base[3] == LeadTwoLow &&
                      (name_base[4] inside {SuperOne, SuperTwo, SuperThree});
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit continuation_fits(input logic [7:0] b, input cont_class_type cls);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      case (cls)
         CONT_FROM_A0: lo = 8'hA0;
         CONT_TO_9F:   hi = 8'h9F;
         CONT_FROM_90: lo = 8'h90;
         CONT_TO_8F:   hi = 8'h8F;
         default: ;
      endcase
      return b >= lo && b <= hi;
   endfunction

   function automatic void decode_lead(input logic [7:0] b);
      if (b <= CharDel) begin
         if (b < CharSpace || b inside {CharDel, CharLess, CharGreater, CharColon, CharQuote,
                                        CharSlash, CharBackslash, CharPipe, CharQuestion,
                                        CharStar})
            name_bad = 1'b1;
      end else if (b inside {[LeadTwoLow:LeadTwoHigh]}) begin
         name_cont_left  = 2'd1;
         name_cont_class = CONT_NORMAL;
      end else if (b inside {[LeadThreeLow:LeadThreeHigh]}) begin
         name_cont_left  = 2'd2;
         name_cont_class = (b == LeadThreeLow)  ? CONT_FROM_A0 :
                           (b == LeadSurrogate) ? CONT_TO_9F : CONT_NORMAL;
      end else if (b inside {[LeadFourLow:LeadFourHigh]}) begin
         name_cont_left  = 2'd3;
         name_cont_class = (b == LeadFourLow)  ? CONT_FROM_90 :
                           (b == LeadFourHigh) ? CONT_TO_8F : CONT_NORMAL;
      end else begin
         name_bad = 1'b1;
      end
   endfunction

   // Advances the predictor by one accepted request; has_result is set on an ending request.
   function automatic void predict_verdict(input logic [7:0] b, input logic last,
                                           input logic empty, output bit has_result,
                                           output bit verdict);
      has_result = 1'b0;
      verdict    = 1'b0;
      if (empty) begin
         has_result = 1'b1;
         clear_name_state();
         return;
      end
      if (name_count >= MaxNameBytesDefault)
         name_bad = 1'b1;
      else
         name_count = name_count + 9'd1;
      if (name_cont_left != 2'd0) begin
         if (continuation_fits(b, name_cont_class)) begin
            name_cont_left = name_cont_left - 2'd1;
         end else begin
            name_bad       = 1'b1;
            name_cont_left = 2'd0;
         end
         name_cont_class = CONT_NORMAL;
      end else begin
         decode_lead(b);
      end
      if (!name_dot_seen) begin
         if (b == CharDot) begin
            name_dot_seen = 1'b1;
         end else begin
            if (name_base_len < BasePrefixDepth) name_base[name_base_len] = b;
            if (name_base_len < BaseLenSaturated) name_base_len = name_base_len + 3'd1;
         end
      end
      if (last) begin
         has_result = 1'b1;
         verdict = !name_bad && name_cont_left == 2'd0 && b != CharDot && b != CharSpace &&
                   !base_is_device();
         clear_name_state();
      end
   endfunction

   // Offers one request, waits for it to be taken and records what it should produce.
   task automatic send_request(input logic [7:0] data, input logic last, input logic empty,
                               input int want);
      bit has_result;
      bit verdict;
      while (idle_enabled && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_last_byte  <= last;
      req_empty_name <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_verdict(data, last, empty, has_result, verdict);
      if (has_result) queue_verdict((want >= 0) ? want[0] : verdict);
      items_sent++;
      @(negedge clock);
   endtask

   // Directed table: a name, how often it repeats, whether an empty marker ends it,
   // and the verdict where it is plain to see (NoWant leaves it to the predictor).
   typedef struct {
      string text;
      int    reps;
      bit    ends_empty;
      int    want;
   } directed_row_type;

   directed_row_type directed_rows [RowCount] = '{
      '{"",                                1,   1'b1, 0},
      '{"ab",                              1,   1'b1, 0},
      '{"a",                               1,   1'b0, 1},
      '{"\377",                            1,   1'b0, 0},
      '{".",                               1,   1'b0, 0},
      '{"..",                              1,   1'b0, 0},
      '{"ab ",                             1,   1'b0, 0},
      '{"a<b",                             1,   1'b0, 0},
      '{"\001",                            1,   1'b0, 0},
      '{"x\177",                           1,   1'b0, 0},
      '{"CoN.txt",                         1,   1'b0, 0},
      '{"com9",                            1,   1'b0, 0},
      '{"LPT\302\271",                     1,   1'b0, 0},
      '{"com0",                            1,   1'b0, NoWant},
      '{"conx.a",                          1,   1'b0, NoWant},
      '{"\300\200",                        1,   1'b0, 0},
      '{"\355\240\200",                    1,   1'b0, 0},
      '{"\364\220\200\200",                1,   1'b0, 0},
      '{"a\342\202",                       1,   1'b0, 0},
      '{"\302A",                           1,   1'b0, 0},
      '{"\342\202\254\360\220\200\200",    1,   1'b0, NoWant},
      '{"x",                               255, 1'b0, 1},
      '{"y",                               256, 1'b0, 0},
      '{"a.b c.d",                         1,   1'b0, NoWant}
   };

   logic [7:0] name_bytes [$];
   string      device_words [8] = '{"con", "PRN", "Aux", "nul", "com", "LPT", "cOm", "lpt"};
   logic [7:0] super_bytes [5]  = '{SuperOne, SuperTwo, SuperThree, 8'hB0, 8'hB1};

   function automatic void add_byte(input logic [7:0] b);
      name_bytes.insert(name_bytes.size(), b);
   endfunction

   task automatic add_utf8_sequence();
      int         len;
      int         r;
      int         keep;
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      len = $urandom_range(2, 4);
      r   = $urandom_range(0, 99);
      case (len)
         2: lead = (r < 10) ? 8'($urandom_range(8'h80, 8'hC1)) :
                   (r < 30) ? LeadTwoLow : (r < 45) ? LeadTwoHigh :
                   8'($urandom_range(LeadTwoLow, LeadTwoHigh));
         3: lead = (r < 25) ? LeadThreeLow : (r < 50) ? LeadSurrogate :
                   (r < 60) ? LeadThreeHigh : 8'($urandom_range(LeadThreeLow, LeadThreeHigh));
         default: lead = (r < 10) ? 8'($urandom_range(8'hF5, 8'hFF)) :
                         (r < 35) ? LeadFourLow : (r < 60) ? LeadFourHigh :
                         8'($urandom_range(LeadFourLow, LeadFourHigh));
      endcase
      lo = 8'h80;
      hi = 8'hBF;
      if (lead == LeadThreeLow)  lo = 8'hA0;
      if (lead == LeadSurrogate) hi = 8'h9F;
      if (lead == LeadFourLow)   lo = 8'h90;
      if (lead == LeadFourHigh)  hi = 8'h8F;
      add_byte(lead);
      // Now and then the sequence is cut short.
      keep = ($urandom_range(0, 99) < 5) ? len - 2 : len - 1;
      for (int i = 0; i < keep; i++) begin
         r = $urandom_range(0, 99);
         if (r < 12)
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
         else if (r < 16)
            add_byte(8'($urandom_range(0, 255)));
         else
            add_byte(8'($urandom_range(lo, hi)));
         lo = 8'h80;
         hi = 8'hBF;
      end
   endtask

   task automatic add_plain_unit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         case ($urandom_range(0, 2))
            0: add_byte(8'($urandom_range(8'h61, 8'h7A)));
            1: add_byte(8'($urandom_range(8'h41, 8'h5A)));
            default: add_byte(8'($urandom_range(8'h30, 8'h39)));
         endcase
      end else if (r < 80) begin
         add_byte(CharDot);
      end else if (r < 85) begin
         add_byte(CharSpace);
      end else if (r < 90) begin
         add_byte(8'($urandom_range(CharSpace, 8'h7E)));
      end else if (r < 92) begin
         add_byte(8'($urandom_range(0, 255)));
      end else begin
         add_utf8_sequence();
      end
   endtask

   task automatic build_random_name();
      int    r;
      int    pick;
      string word;
      name_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 5) begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end else if (r < 6) begin
         repeat ($urandom_range(MaxNameBytesDefault - 5, MaxNameBytesDefault + 7))
            add_byte(8'($urandom_range(8'h61, 8'h7A)));
      end else if (r < 30) begin
         pick = $urandom_range(0, 7);
         word = device_words[pick];
         for (int i = 0; i < word.len(); i++) add_byte(word[i]);
         // The last four words are com and lpt, which may take a digit or superscript.
         if (pick >= 4) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               add_byte(8'($urandom_range(8'h30, 8'h39)));
            end else if (r < 90) begin
               add_byte(LeadTwoLow);
               add_byte(super_bytes[$urandom_range(0, 4)]);
            end
         end
         if ($urandom_range(0, 99) < 15) add_plain_unit();
         if ($urandom_range(0, 99) < 50) begin
            add_byte(CharDot);
            repeat ($urandom_range(1, 4)) add_plain_unit();
         end
      end else begin
         repeat ($urandom_range(1, 12)) add_plain_unit();
      end
   endtask

   task automatic send_random_name();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_request(8'($urandom), 1'($urandom), 1'b1, NoWant);
      end else begin
         foreach (name_bytes[i])
            send_request(name_bytes[i], r >= 7 && i == name_bytes.size() - 1, 1'b0, NoWant);
         // An empty marker can also cut a half-received name short.
         if (r < 7) send_request(8'($urandom), 1'($urandom), 1'b1, NoWant);
      end
   endtask

   initial begin
      int  random_start;
      int  progress;
      int  final_index;
      bit  held;
      bit  paused;
      held           = 1'b0;
      paused         = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_last_byte  = 1'b0;
      req_empty_name = 1'b0;
      clear_name_state();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < RowCount; row++) begin
         name_bytes.delete();
         repeat (directed_rows[row].reps)
            for (int i = 0; i < directed_rows[row].text.len(); i++)
               add_byte(directed_rows[row].text[i]);
         final_index = name_bytes.size() - 1;
         if (directed_rows[row].ends_empty) begin
            foreach (name_bytes[i]) send_request(name_bytes[i], 1'b0, 1'b0, NoWant);
            send_request(name_bytes.size() == 0 ? 8'h00 : 8'hFF, name_bytes.size() != 0,
                         1'b1, directed_rows[row].want);
         end else begin
            foreach (name_bytes[i])
               send_request(name_bytes[i], i == final_index, 1'b0,
                            i == final_index ? directed_rows[row].want : NoWant);
         end
      end

      // The random part tops the run up to the planned number of requests.
      random_start = items_sent;
      while (items_sent < TotalItems) begin
         progress = items_sent - random_start;
         idle_enabled = !(progress >= 300 && progress < 600);
         if (!held && progress >= 150) begin
            held = 1'b1;
            hold_request = 1'b1;
         end
         if (!paused && progress >= 700) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(negedge clock); while (verdicts_due.size() != 0);
         end
         build_random_name();
         send_random_name();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_due.size() != 0);
      repeat (DrainCycles) @(posedge clock);
      $display("Summary: %0d requests sent, %0d names checked (%0d accepted, %0d rejected).",
               items_sent, names_checked, names_accepted, names_checked - names_accepted);
      $display("Covered reserved bases, UTF-8 edge cases, the %0d-byte limit and back-pressure.",
               MaxNameBytesDefault);
      if (mismatch_count == 0)
         $display("path_component_validator_top verification clean");
      else
         $display("path_component_validator_top verification failed");
      $finish;
   end

   // Response side: random stalls, one long hold-off on request, and a quiet stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= idle_enabled && ($urandom_range(0, 99) < IdlePercent);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $error("name_valid arrived with no request outstanding: actual %0d",
                      rsp_name_valid);
               mismatch_count++;
            end else begin
               expected_verdict = verdicts_due.pop_front();
               if (rsp_name_valid !== expected_verdict) begin
                  $error("name_valid mismatch: expected %0d, actual %0d",
                         expected_verdict, rsp_name_valid);
                  mismatch_count++;
               end
               names_checked++;
               if (expected_verdict) names_accepted++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QuietLimit) begin
            $display("path_component_validator_top verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

endmodule

/* files.f */
rtl/pcv_pkg.sv
rtl/path_component_validator_top.sv
dv/testbench.sv
